/* rtl/core/sfcd_pkg.sv */
package sfcd_pkg;

    // Frame and result kinds
    typedef enum logic {
        KIND_MEAS   = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    // Result error codes
    typedef enum logic [1:0] {
        ERR_OK         = 2'd0,
        ERR_FIRST_CRC  = 2'd1,
        ERR_SECOND_CRC = 2'd2
    } t_err;

    // Byte positions inside a frame
    localparam logic [2:0] POS_W1_HI  = 3'd0;
    localparam logic [2:0] POS_W1_LO  = 3'd1;
    localparam logic [2:0] POS_W1_CRC = 3'd2;
    localparam logic [2:0] POS_W2_HI  = 3'd3;
    localparam logic [2:0] POS_W2_LO  = 3'd4;
    localparam logic [2:0] POS_W2_CRC = 3'd5;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Scaling: temperature -4500 + 17500*raw/65535, humidity 10000*raw/65535
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [16:0] SCALE_DIV   = 17'd65535;

    // 17500 * 65535 needs 31 bits
    localparam int PROD_W = 31;

    // One finished frame, handed from the front to the back
    typedef struct packed {
        t_kind       kind;
        t_err        err;
        logic [15:0] word_a;
        logic [15:0] word_b;
    } t_job;

    // CRC-8, MSB first, over one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // floor(x / 65535) for x < 2^31 - 2^15: x = q0*65535 + (q0 + lo), one correction
    function automatic logic [14:0] div_65535(input logic [PROD_W-1:0] x);
        logic [14:0] q0;
        logic [16:0] rem;
        logic [14:0] q;
        q0  = x[PROD_W-1:16];
        rem = {1'b0, x[15:0]} + {2'b00, q0};
        if (rem >= SCALE_DIV) begin
            q = q0 + 15'd1;
        end else begin
            q = q0;
        end
        return q;
    endfunction

endpackage

/* rtl/core/sfcd_front.sv */
module sfcd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_frame_start,
    input  logic                 i_frame_kind,
    output logic                 o_push,
    output sfcd_pkg::t_job       o_job
);

    logic [2:0]             r_pos, n_pos;
    logic [7:0]             r_crc, n_crc;
    logic [15:0]            r_w1, n_w1;
    logic [15:0]            r_w2, n_w2;
    sfcd_pkg::t_kind        r_kind, n_kind;
    logic                   r_first_bad, n_first_bad;

    logic [2:0]             pos;
    logic [7:0]             crc_cur;
    logic [7:0]             crc_upd;
    logic                   crc_bad;

    always_comb begin
        n_kind = i_frame_start ? sfcd_pkg::t_kind'(i_frame_kind) : r_kind;
        pos     = i_frame_start ? sfcd_pkg::POS_W1_HI : r_pos;
        crc_cur = (pos == sfcd_pkg::POS_W1_HI) ? sfcd_pkg::CRC_INIT : r_crc;
        crc_upd = sfcd_pkg::crc8_byte(crc_cur, i_rx_byte);
        crc_bad = (crc_cur != i_rx_byte);

        n_pos       = r_pos;
        n_crc       = r_crc;
        n_w1        = r_w1;
        n_w2        = r_w2;
        n_first_bad = r_first_bad;
        o_push      = 1'b0;
        o_job.kind   = n_kind;
        o_job.err    = sfcd_pkg::ERR_OK;
        o_job.word_a = r_w1;
        o_job.word_b = r_w2;

        if (n_kind == sfcd_pkg::KIND_STATUS) begin
            case (pos)
                sfcd_pkg::POS_W1_HI: begin
                    n_w1  = {i_rx_byte, r_w1[7:0]};
                    n_crc = crc_upd;
                    n_pos = sfcd_pkg::POS_W1_LO;
                end
                sfcd_pkg::POS_W1_LO: begin
                    n_w1  = {r_w1[15:8], i_rx_byte};
                    n_crc = crc_upd;
                    n_pos = sfcd_pkg::POS_W1_CRC;
                end
                default: begin
                    n_pos     = sfcd_pkg::POS_W1_HI;
                    n_crc     = sfcd_pkg::CRC_INIT;
                    o_push    = 1'b1;
                    o_job.err = crc_bad ? sfcd_pkg::ERR_FIRST_CRC : sfcd_pkg::ERR_OK;
                end
            endcase
        end else begin
            case (pos)
                sfcd_pkg::POS_W1_HI: begin
                    n_w1  = {i_rx_byte, r_w1[7:0]};
                    n_crc = crc_upd;
                    n_pos = sfcd_pkg::POS_W1_LO;
                end
                sfcd_pkg::POS_W1_LO: begin
                    n_w1  = {r_w1[15:8], i_rx_byte};
                    n_crc = crc_upd;
                    n_pos = sfcd_pkg::POS_W1_CRC;
                end
                sfcd_pkg::POS_W1_CRC: begin
                    n_first_bad = crc_bad;
                    n_crc       = sfcd_pkg::CRC_INIT;
                    n_pos       = sfcd_pkg::POS_W2_HI;
                end
                sfcd_pkg::POS_W2_HI: begin
                    n_w2  = {i_rx_byte, r_w2[7:0]};
                    n_crc = crc_upd;
                    n_pos = sfcd_pkg::POS_W2_LO;
                end
                sfcd_pkg::POS_W2_LO: begin
                    n_w2  = {r_w2[15:8], i_rx_byte};
                    n_crc = crc_upd;
                    n_pos = sfcd_pkg::POS_W2_CRC;
                end
                default: begin
                    n_pos  = sfcd_pkg::POS_W1_HI;
                    n_crc  = sfcd_pkg::CRC_INIT;
                    o_push = 1'b1;
                    if (r_first_bad) begin
                        o_job.err = sfcd_pkg::ERR_FIRST_CRC;
                    end else if (crc_bad) begin
                        o_job.err = sfcd_pkg::ERR_SECOND_CRC;
                    end else begin
                        o_job.err = sfcd_pkg::ERR_OK;
                    end
                end
            endcase
        end
        o_push = o_push & i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= sfcd_pkg::POS_W1_HI;
            r_crc       <= sfcd_pkg::CRC_INIT;
            r_w1        <= '0;
            r_w2        <= '0;
            r_kind      <= sfcd_pkg::KIND_MEAS;
            r_first_bad <= 1'b0;
        end else if (i_accept) begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_w1        <= n_w1;
            r_w2        <= n_w2;
            r_kind      <= n_kind;
            r_first_bad <= n_first_bad;
        end
    end

endmodule

/* rtl/core/sfcd_queue.sv */
module sfcd_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sfcd_pkg::t_job   i_job,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output sfcd_pkg::t_job   o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sfcd_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* rtl/core/sfcd_back.sv */
module sfcd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  sfcd_pkg::t_job        i_job,
    output logic                  o_pop,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic                  o_result_kind,
    output logic [1:0]            o_error_code,
    output logic signed [14:0]    o_temperature_centi,
    output logic [13:0]           o_humidity_centi,
    output logic [15:0]           o_status_word
);

    // Multiply stage
    logic                          r_s1_valid;
    sfcd_pkg::t_kind               r_s1_kind;
    sfcd_pkg::t_err                r_s1_err;
    logic [15:0]                   r_s1_word;
    logic [sfcd_pkg::PROD_W-1:0]   r_s1_prod_t;
    logic [sfcd_pkg::PROD_W-1:0]   r_s1_prod_h;

    // Output register
    logic                          r_out_valid;
    logic                          r_out_kind;
    logic [1:0]                    r_out_err;
    logic [14:0]                   r_out_temp;
    logic [13:0]                   r_out_hum;
    logic [15:0]                   r_out_status;

    logic                          out_adv;
    logic                          s1_adv;
    logic [14:0]                   q_t;
    logic [14:0]                   q_h;
    logic [15:0]                   temp_full;
    logic [14:0]                   n_temp;
    logic [13:0]                   n_hum;
    logic [15:0]                   n_status;

    assign out_adv = !r_out_valid || !i_stall;
    assign s1_adv  = !r_s1_valid || out_adv;
    assign o_pop   = i_job_valid && s1_adv;

    always_comb begin
        q_t       = sfcd_pkg::div_65535(r_s1_prod_t);
        q_h       = sfcd_pkg::div_65535(r_s1_prod_h);
        temp_full = {1'b0, q_t} - sfcd_pkg::TEMP_OFFSET;
        n_temp    = '0;
        n_hum     = '0;
        n_status  = '0;
        if (r_s1_err == sfcd_pkg::ERR_OK) begin
            if (r_s1_kind == sfcd_pkg::KIND_STATUS) begin
                n_status = r_s1_word;
            end else begin
                n_temp = temp_full[14:0];
                n_hum  = q_h[13:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_job_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_kind   <= i_job.kind;
            r_s1_err    <= i_job.err;
            r_s1_word   <= i_job.word_a;
            r_s1_prod_t <= sfcd_pkg::PROD_W'(sfcd_pkg::TEMP_SPAN)
                           * sfcd_pkg::PROD_W'(i_job.word_a);
            r_s1_prod_h <= sfcd_pkg::PROD_W'(sfcd_pkg::HUM_SPAN)
                           * sfcd_pkg::PROD_W'(i_job.word_b);
        end
        if (out_adv && r_s1_valid) begin
            r_out_kind   <= r_s1_kind;
            r_out_err    <= r_s1_err;
            r_out_temp   <= n_temp;
            r_out_hum    <= n_hum;
            r_out_status <= n_status;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_result_kind       = r_out_kind;
    assign o_error_code        = r_out_err;
    assign o_temperature_centi = $signed(r_out_temp);
    assign o_humidity_centi    = r_out_hum;
    assign o_status_word       = r_out_status;

endmodule

/* rtl/core/sensor_frame_crc_decoder.sv */
// Channel   Handshake            Payload
// ------    -------------------  ---------------------------------------------------------
// input     i_valid / o_stall    i_rx_byte, i_frame_start, i_frame_kind
// output    o_valid / i_stall    o_result_kind, o_error_code, o_temperature_centi,
//                                o_humidity_centi, o_status_word
//
// One byte item is taken every cycle while the frame queue has room.
// After the last byte of its frame is taken, a result passes through the queue,
// the multiply stage and the output register before it appears on the output.
// Reset (synchronous, active low) empties the queue and the pipeline and restarts
// framing at the first byte of a measurement frame.
// A stall on the output holds the back pipeline; bytes keep flowing until the
// QUEUE_DEPTH-entry queue fills, which raises o_stall.
module sensor_frame_crc_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_frame_start,
    input  logic                 i_frame_kind,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_result_kind,
    output logic [1:0]           o_error_code,
    output logic signed [14:0]   o_temperature_centi,
    output logic [13:0]          o_humidity_centi,
    output logic [15:0]          o_status_word
);

    logic            accept;
    logic            push;
    sfcd_pkg::t_job  front_job;
    logic            queue_full;
    logic            queue_valid;
    sfcd_pkg::t_job  queue_job;
    logic            pop;

    // Take a byte only when the queue can hold whatever frame it closes
    assign o_stall = queue_full;
    assign accept  = i_valid && !queue_full;

    // Front: track byte position, run the CRC, assemble words, close frames
    sfcd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .i_frame_kind  (i_frame_kind),
        .o_push        (push),
        .o_job         (front_job)
    );

    // Hold finished frames so that an output stall does not stop the byte stream
    sfcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_job   (queue_job)
    );

    // Back: scale the raw words, zero fields on error, drive the result
    sfcd_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_job_valid         (queue_valid),
        .i_job               (queue_job),
        .o_pop               (pop),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_result_kind       (o_result_kind),
        .o_error_code        (o_error_code),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_centi    (o_humidity_centi),
        .o_status_word       (o_status_word)
    );

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int ITEM_COUNT     = 1150;
    localparam int WATCHDOG_LIMIT = 4000;
    // Margin after the last predicted result, to catch any stray extra result.
    localparam int DRAIN_CYCLES   = 8;

    // Scoreboard: tracks the decoder state, predicts each result and checks
    // the results that leave the block against those predictions, in order.
    class decode_scoreboard;
        typedef struct {
            sfcd_pkg::t_kind    kind;
            sfcd_pkg::t_err     err;
            logic signed [14:0] temp;
            logic [13:0]        hum;
            logic [15:0]        status;
        } t_reading;

        t_reading    reading_q[$];
        int          errors;
        int          checked;
        int          meas_ok;
        int          status_ok;
        int          crc_failures;

        logic [2:0]  byte_pos;
        logic [7:0]  crc_acc;
        logic [15:0] word_a;
        logic [15:0] word_b;
        sfcd_pkg::t_kind kind_held;
        bit          word_a_bad;

        function new();
            errors       = 0;
            checked      = 0;
            meas_ok      = 0;
            status_ok    = 0;
            crc_failures = 0;
            byte_pos     = 3'd0;
            crc_acc      = 8'hFF;
            word_a       = 16'd0;
            word_b       = 16'd0;
            kind_held    = sfcd_pkg::KIND_MEAS;
            word_a_bad   = 1'b0;
        endfunction

        // CRC-8 (x^8 + x^5 + x^4 + 1), one data bit at a time, MSB first.
        static function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] data);
            logic [7:0] c;
            logic       fb;
            c = crc;
            for (int i = 7; i >= 0; i--) begin
                fb = c[7] ^ data[i];
                c  = {c[6:0], 1'b0};
                if (fb) begin
                    c = c ^ 8'h31;
                end
            end
            return c;
        endfunction

        static function logic [7:0] word_crc(logic [15:0] w);
            return crc_step(crc_step(8'hFF, w[15:8]), w[7:0]);
        endfunction

        function int pending();
            return reading_q.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) begin
                $display("MISMATCH at %0t: %s", $time, msg);
            end
        endtask

        function void push_reading(sfcd_pkg::t_kind k, sfcd_pkg::t_err e,
                                   logic signed [14:0] t, logic [13:0] h,
                                   logic [15:0] s);
            t_reading r;
            r.kind   = k;
            r.err    = e;
            r.temp   = t;
            r.hum    = h;
            r.status = s;
            reading_q.push_back(r);
        endfunction

        // Advance the decoder state by one accepted byte item.
        function void note_byte(logic [7:0] rx, bit start, bit kind);
            int unsigned scaled_t;
            int unsigned scaled_h;
            bit          word_b_bad;
            if (start) begin
                kind_held = sfcd_pkg::t_kind'(kind);
                byte_pos  = 3'd0;
            end
            if (byte_pos == 3'd0) begin
                crc_acc = 8'hFF;
            end
            if (kind_held == sfcd_pkg::KIND_STATUS) begin
                case (byte_pos)
                    3'd0: begin
                        word_a[15:8] = rx;
                        crc_acc      = crc_step(crc_acc, rx);
                        byte_pos     = 3'd1;
                    end
                    3'd1: begin
                        word_a[7:0] = rx;
                        crc_acc     = crc_step(crc_acc, rx);
                        byte_pos    = 3'd2;
                    end
                    default: begin
                        byte_pos = 3'd0;
                        if (crc_acc != rx) begin
                            push_reading(sfcd_pkg::KIND_STATUS, sfcd_pkg::ERR_FIRST_CRC,
                                         '0, '0, '0);
                        end else begin
                            push_reading(sfcd_pkg::KIND_STATUS, sfcd_pkg::ERR_OK,
                                         '0, '0, word_a);
                        end
                        crc_acc = 8'hFF;
                    end
                endcase
            end else begin
                case (byte_pos)
                    3'd0: begin
                        word_a[15:8] = rx;
                        crc_acc      = crc_step(crc_acc, rx);
                        byte_pos     = 3'd1;
                    end
                    3'd1: begin
                        word_a[7:0] = rx;
                        crc_acc     = crc_step(crc_acc, rx);
                        byte_pos    = 3'd2;
                    end
                    3'd2: begin
                        word_a_bad = (crc_acc != rx);
                        crc_acc    = 8'hFF;
                        byte_pos   = 3'd3;
                    end
                    3'd3: begin
                        word_b[15:8] = rx;
                        crc_acc      = crc_step(crc_acc, rx);
                        byte_pos     = 3'd4;
                    end
                    3'd4: begin
                        word_b[7:0] = rx;
                        crc_acc     = crc_step(crc_acc, rx);
                        byte_pos    = 3'd5;
                    end
                    default: begin
                        word_b_bad = (crc_acc != rx);
                        byte_pos   = 3'd0;
                        crc_acc    = 8'hFF;
                        if (word_a_bad) begin
                            push_reading(sfcd_pkg::KIND_MEAS, sfcd_pkg::ERR_FIRST_CRC,
                                         '0, '0, '0);
                        end else if (word_b_bad) begin
                            push_reading(sfcd_pkg::KIND_MEAS, sfcd_pkg::ERR_SECOND_CRC,
                                         '0, '0, '0);
                        end else begin
                            scaled_t = (32'd17500 * {16'd0, word_a}) / 32'd65535;
                            scaled_h = (32'd10000 * {16'd0, word_b}) / 32'd65535;
                            push_reading(sfcd_pkg::KIND_MEAS, sfcd_pkg::ERR_OK,
                                         15'(int'(scaled_t) - 4500),
                                         14'(scaled_h), '0);
                        end
                    end
                endcase
            end
        endfunction

        // Compare one accepted result with the oldest prediction.
        task check_result(sfcd_pkg::t_kind k, sfcd_pkg::t_err e, logic signed [14:0] t,
                          logic [13:0] h, logic [15:0] s);
            t_reading exp_r;
            if (reading_q.size() == 0) begin
                report($sformatf("result with nothing predicted (kind %0d err %0d)",
                                 k, e));
                return;
            end
            exp_r = reading_q.pop_front();
            checked++;
            if (exp_r.err != sfcd_pkg::ERR_OK) begin
                crc_failures++;
            end else if (exp_r.kind == sfcd_pkg::KIND_STATUS) begin
                status_ok++;
            end else begin
                meas_ok++;
            end
            if (k !== exp_r.kind) begin
                report($sformatf("result_kind %0d, want %0d", k, exp_r.kind));
            end
            if (e !== exp_r.err) begin
                report($sformatf("error_code %0d, want %0d", e, exp_r.err));
            end
            if (t !== exp_r.temp) begin
                report($sformatf("temperature_centi %0d, want %0d", t, exp_r.temp));
            end
            if (h !== exp_r.hum) begin
                report($sformatf("humidity_centi %0d, want %0d", h, exp_r.hum));
            end
            if (s !== exp_r.status) begin
                report($sformatf("status_word %h, want %h", s, exp_r.status));
            end
        endtask

        task flush_check();
            while (reading_q.size() != 0) begin
                void'(reading_q.pop_front());
                report("predicted result never arrived");
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_rx_byte;
    logic               i_frame_start;
    logic               i_frame_kind;
    logic               o_valid;
    logic               i_stall;
    logic               o_result_kind;
    logic [1:0]         o_error_code;
    logic signed [14:0] o_temperature_centi;
    logic [13:0]        o_humidity_centi;
    logic [15:0]        o_status_word;

    decode_scoreboard sb;
    int               items_sent   = 0;
    int               quiet_cycles = 0;
    int               send_idle_pct = 9;
    int               stall_pct     = 71;

    sensor_frame_crc_decoder u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_rx_byte           (i_rx_byte),
        .i_frame_start       (i_frame_start),
        .i_frame_kind        (i_frame_kind),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_result_kind       (o_result_kind),
        .o_error_code        (o_error_code),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_centi    (o_humidity_centi),
        .o_status_word       (o_status_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver back-pressure: redraw the stall at every falling edge, held
    // low while in reset.
    always @(negedge i_clk) begin
        i_stall = i_rst_n && ($urandom_range(99) < stall_pct);
    end

    // Check every result item taken from the output channel.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(sfcd_pkg::t_kind'(o_result_kind),
                            sfcd_pkg::t_err'(o_error_code),
                            o_temperature_centi, o_humidity_centi, o_status_word);
        end
    end

    // Watchdog: count cycles in which neither channel moves an item, and
    // abandon the run if the block appears hung.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL sensor_frame_crc_decoder");
            $finish;
        end
    end

    // Idling runs in three phases over the item count: a busy sender against
    // a lazy receiver, then the reverse, then both flat out.
    function void update_idle_phase();
        case (items_sent * 3 / ITEM_COUNT)
            0: begin
                send_idle_pct = 9;
                stall_pct     = 71;
            end
            1: begin
                send_idle_pct = 71;
                stall_pct     = 9;
            end
            default: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
        endcase
    endfunction

    // Drive one byte item: optionally idle first, then hold the payload until
    // the block takes it, and note it in the scoreboard.
    task automatic send_byte(logic [7:0] b, bit start, bit kind);
        update_idle_phase();
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_rx_byte     = b;
        i_frame_start = start;
        i_frame_kind  = kind;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        sb.note_byte(b, start, kind);
        items_sent++;
    endtask

    // Send a whole frame; a bad CRC is the right one with some bits flipped.
    // Only the first byte can carry a frame start; the kind bit on the others
    // is junk that the block must ignore.
    task automatic send_frame(sfcd_pkg::t_kind kind, bit with_start, logic [15:0] w_a,
                              logic [15:0] w_b, bit bad_a, bit bad_b);
        logic [7:0] bytes[6];
        int         n;
        bytes[0] = w_a[15:8];
        bytes[1] = w_a[7:0];
        bytes[2] = decode_scoreboard::word_crc(w_a);
        if (bad_a) begin
            bytes[2] = bytes[2] ^ 8'($urandom_range(1, 255));
        end
        bytes[3] = w_b[15:8];
        bytes[4] = w_b[7:0];
        bytes[5] = decode_scoreboard::word_crc(w_b);
        if (bad_b) begin
            bytes[5] = bytes[5] ^ 8'($urandom_range(1, 255));
        end
        n = (kind == sfcd_pkg::KIND_STATUS) ? 3 : 6;
        for (int i = 0; i < n; i++) begin
            if (i == 0) begin
                send_byte(bytes[i], with_start, kind);
            end else begin
                send_byte(bytes[i], 1'b0, 1'($urandom_range(1)));
            end
        end
    endtask

    // Favour the scale end points, else any word.
    function automatic logic [15:0] pick_word();
        int r;
        r = $urandom_range(9);
        if (r == 0) begin
            return 16'h0000;
        end else if (r == 1) begin
            return 16'hFFFF;
        end
        return 16'($urandom);
    endfunction

    initial begin
        sfcd_pkg::t_kind last_kind;
        bit              aligned;
        bit              with_start;
        sfcd_pkg::t_kind kind;
        int              r;
        int              cut;

        sb            = new();
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_rx_byte     = 8'd0;
        i_frame_start = 1'b0;
        i_frame_kind  = 1'b0;
        i_stall       = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part.
        // Bytes straight after reset, no frame start: decode as a measurement.
        send_frame(sfcd_pkg::KIND_MEAS, 1'b0, 16'h0000, 16'hFFFF, 1'b0, 1'b0);
        // Follow-on frame of the latched kind, opposite scale extremes.
        send_frame(sfcd_pkg::KIND_MEAS, 1'b0, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
        // Abandon a measurement after one byte with a status frame start;
        // its CRC is bad.
        send_byte(8'hA5, 1'b1, sfcd_pkg::KIND_MEAS);
        send_frame(sfcd_pkg::KIND_STATUS, 1'b1, 16'hFFFF, 16'h0000, 1'b1, 1'b0);
        // Status frame continued without a start, good CRC.
        send_frame(sfcd_pkg::KIND_STATUS, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0);
        // Both measurement CRCs bad: the first word must win.
        send_frame(sfcd_pkg::KIND_MEAS, 1'b1, 16'h8000, 16'h7FFF, 1'b1, 1'b1);
        // Only the second measurement CRC bad.
        send_frame(sfcd_pkg::KIND_MEAS, 1'b1, 16'h7FFF, 16'h8000, 1'b0, 1'b1);
        last_kind = sfcd_pkg::KIND_MEAS;
        aligned   = 1'b1;

        // Random part: mostly well-formed frames with random words, laced
        // with stray bytes and frames cut short.
        while (items_sent < ITEM_COUNT) begin
            r = $urandom_range(99);
            if (r < 8) begin
                send_byte(8'($urandom), ($urandom_range(3) == 0),
                          1'($urandom_range(1)));
                aligned = 1'b0;
            end else if (r < 14) begin
                kind = sfcd_pkg::t_kind'($urandom_range(1));
                cut  = (kind == sfcd_pkg::KIND_STATUS) ? $urandom_range(1, 2)
                                                       : $urandom_range(1, 5);
                for (int i = 0; i < cut; i++) begin
                    send_byte(8'($urandom), (i == 0), kind);
                end
                aligned = 1'b0;
            end else begin
                kind       = sfcd_pkg::t_kind'($urandom_range(1));
                with_start = !aligned || ($urandom_range(3) != 0);
                if (!with_start) begin
                    kind = last_kind;
                end
                send_frame(kind, with_start, pick_word(), pick_word(),
                           ($urandom_range(9) == 0), ($urandom_range(9) == 0));
                last_kind = kind;
                aligned   = 1'b1;
            end
        end
        @(negedge i_clk);
        i_valid = 1'b0;

        // Drain: wait for every predicted result, then a few idle cycles so
        // that any stray extra result is caught.
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.flush_check();

        $display("Sent %0d byte items; checked %0d results.", items_sent, sb.checked);
        $display("Good measurements %0d, good status words %0d, CRC failures %0d.",
                 sb.meas_ok, sb.status_ok, sb.crc_failures);
        if (sb.errors == 0) begin
            $display("PASS sensor_frame_crc_decoder");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("FAIL sensor_frame_crc_decoder");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/sfcd_pkg.sv
rtl/core/sfcd_front.sv
rtl/core/sfcd_queue.sv
rtl/core/sfcd_back.sv
rtl/core/sensor_frame_crc_decoder.sv
test/testbench.sv
